FILE: rtl/line_edit_buffer_macros.svh
// Assertion macros for the line editor; clocked on clk, quiet during reset.
`ifndef LINE_EDIT_BUFFER_MACROS_SVH
`define LINE_EDIT_BUFFER_MACROS_SVH
`ifndef SYNTH
`define LEB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("line_edit_buffer: assertion failed");
`define LEB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("line_edit_buffer: assertion failed");
`else
`define LEB_ASSERT_IMP(lbl, ante, cons)
`define LEB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/leb_pkg.sv
`timescale 1ns / 1ps
package leb_pkg;
	localparam int MAX_LINE = 64;
	localparam int POS_W = $clog2(MAX_LINE + 1);
	localparam int OUT_W = 7;
	localparam int CHAR_W = 8;
	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

	localparam logic [3:0] KIND_CHAR = 4'd0;
	localparam logic [3:0] KIND_BACKSPACE = 4'd1;
	localparam logic [3:0] KIND_ERASE = 4'd2;
	localparam logic [3:0] KIND_ESCAPE = 4'd3;
	localparam logic [3:0] KIND_LEFT = 4'd4;
	localparam logic [3:0] KIND_RIGHT = 4'd5;
	localparam logic [3:0] KIND_HOME = 4'd6;
	localparam logic [3:0] KIND_END = 4'd7;
	localparam logic [3:0] KIND_RETURN = 4'd8;

	localparam logic [1:0] RK_STATUS = 2'd0;
	localparam logic [1:0] RK_CHAR = 2'd1;
	localparam logic [1:0] RK_EMPTY = 2'd2;

	localparam logic REG_MAX_LENGTH = 1'b0;
	localparam logic REG_CAPS_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_DELETE = 3'd2,
		CELL_CLEAR = 3'd3,
		CELL_SHIFT = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] len;
		logic [CHAR_W-1:0] ch;
	} cell_cmd_t;
endpackage

FILE: rtl/line_edit_buffer.sv
`timescale 1ns / 1ps
// Line editor built as a row of character cells; an edit shifts the affected cells together.
// Edit keys: status strobed on valid in the cycle after start, a new key every cycle while not busy.
// Return on a line of n characters: busy while they are emitted, characters strobed on
// valid one per cycle after the emit state register, as the row shifts toward cell 0.
// Reset (arst_n low, asynchronous): line all spaces, cursor and length 0,
// max_length 64, caps off. Results cannot be stalled by the receiver.
`include "line_edit_buffer_macros.svh"
module line_edit_buffer import leb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [3:0] kind,
	input logic [7:0] char_code,
	input logic cfg_we,
	input logic cfg_index,
	input logic [6:0] cfg_data,
	output logic valid,
	output logic [1:0] result_kind,
	output logic applied,
	output logic [7:0] char_out,
	output logic [6:0] position,
	output logic [6:0] length_out,
	output logic last
);
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	logic [POS_W-1:0] cursor_q, length_q, emit_idx_q, emit_len_q;
	logic [6:0] max_length_q;
	logic caps_q;
	logic valid_q, last_q, applied_q;
	logic [1:0] rk_q;
	logic [CHAR_W-1:0] char_q;
	logic [6:0] pos_q, len_q;

	logic accept;
	logic [POS_W-1:0] limit;
	logic [CHAR_W-1:0] ins_char;
	logic [POS_W-1:0] cursor_d, length_d;
	logic applied_d;
	logic emit_last;
	cell_cmd_t cmd;
	logic [CHAR_W-1:0] cell_data [MAX_LINE];

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign limit = (max_length_q < 7'(MAX_LINE)) ? POS_W'(max_length_q) : POS_W'(MAX_LINE);
	assign ins_char = (caps_q && char_code > 8'h60 && char_code < 8'h7b)
		? (char_code - SPACE_CHAR) : char_code;
	assign emit_last = (emit_idx_q == emit_len_q - POS_W'(1));

	always_comb begin
		cmd.op = CELL_HOLD;
		cmd.pos = cursor_q;
		cmd.len = length_q;
		cmd.ch = ins_char;
		cursor_d = cursor_q;
		length_d = length_q;
		applied_d = 1'b0;
		if (state_q == ST_EMIT) begin
			cmd.op = CELL_SHIFT;
		end else if (accept) begin
			case (kind)
				KIND_CHAR: begin
					if (length_q < limit && char_code >= 8'd32) begin
						cmd.op = CELL_INSERT;
						cursor_d = cursor_q + POS_W'(1);
						length_d = length_q + POS_W'(1);
						applied_d = 1'b1;
					end
				end
				KIND_BACKSPACE: begin
					if (length_q != '0 && cursor_q != '0) begin
						cmd.op = CELL_DELETE;
						cmd.pos = cursor_q - POS_W'(1);
						cursor_d = cursor_q - POS_W'(1);
						length_d = length_q - POS_W'(1);
						applied_d = 1'b1;
					end
				end
				KIND_ERASE: begin
					if (cursor_q < length_q) begin
						cmd.op = CELL_DELETE;
						length_d = length_q - POS_W'(1);
						applied_d = 1'b1;
					end
				end
				KIND_ESCAPE: begin
					if (length_q != '0) begin
						cmd.op = CELL_CLEAR;
						cursor_d = '0;
						length_d = '0;
						applied_d = 1'b1;
					end
				end
				KIND_LEFT: begin
					if (cursor_q != '0) begin
						cursor_d = cursor_q - POS_W'(1);
						applied_d = 1'b1;
					end
				end
				KIND_RIGHT: begin
					if (cursor_q < length_q) begin
						cursor_d = cursor_q + POS_W'(1);
						applied_d = 1'b1;
					end
				end
				KIND_HOME: begin
					if (cursor_q != '0) begin
						cursor_d = '0;
						applied_d = 1'b1;
					end
				end
				KIND_END: begin
					if (cursor_q < length_q) begin
						cursor_d = length_q;
						applied_d = 1'b1;
					end
				end
				// line stays in the cells and is shifted out during emission
				KIND_RETURN: begin
					cursor_d = '0;
					length_d = '0;
				end
				default: applied_d = 1'b0;
			endcase
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_LINE; g++) begin : g_cell
			logic [CHAR_W-1:0] left_in, right_in;
			if (g == 0) begin : g_first
				assign left_in = SPACE_CHAR;
			end else begin : g_mid_l
				assign left_in = cell_data[g-1];
			end
			if (g == MAX_LINE - 1) begin : g_end
				assign right_in = SPACE_CHAR;
			end else begin : g_mid_r
				assign right_in = cell_data[g+1];
			end
			leb_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.index(POS_W'(g)),
				.cmd(cmd),
				.left_data(left_in),
				.right_data(right_in),
				.data(cell_data[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_q <= '0;
			length_q <= '0;
			emit_idx_q <= '0;
			emit_len_q <= '0;
			max_length_q <= 7'(MAX_LINE);
			caps_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_LENGTH: max_length_q <= cfg_data;
					REG_CAPS_ENABLE: caps_q <= cfg_data[0];
					default: caps_q <= caps_q;
				endcase
			end
			cursor_q <= cursor_d;
			length_q <= length_d;
			valid_q <= 1'b0;
			case (state_q)
				ST_EMIT: begin
					valid_q <= 1'b1;
					emit_idx_q <= emit_idx_q + POS_W'(1);
					if (emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_RETURN && length_q != '0) begin
							state_q <= ST_EMIT;
							emit_idx_q <= '0;
							emit_len_q <= length_q;
						end else begin
							valid_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			rk_q <= RK_CHAR;
			applied_q <= 1'b1;
			char_q <= cell_data[0];
			pos_q <= 7'(emit_idx_q);
			len_q <= 7'(emit_len_q);
			last_q <= emit_last;
		end else if (accept && kind == KIND_RETURN) begin
			rk_q <= RK_EMPTY;
			applied_q <= 1'b0;
			char_q <= '0;
			pos_q <= '0;
			len_q <= '0;
			last_q <= 1'b1;
		end else if (accept) begin
			rk_q <= RK_STATUS;
			applied_q <= applied_d;
			char_q <= '0;
			pos_q <= 7'(cursor_d);
			len_q <= 7'(length_d);
			last_q <= 1'b1;
		end
	end

	assign valid = valid_q;
	assign result_kind = rk_q;
	assign applied = applied_q;
	assign char_out = char_q;
	assign position = pos_q;
	assign length_out = len_q;
	assign last = last_q;

	`LEB_ASSERT_IMP(a_cursor_in_line, 1'b1, cursor_q <= length_q)
	`LEB_ASSERT_IMP(a_length_in_range, 1'b1, length_q <= POS_W'(MAX_LINE))
	`LEB_ASSERT_NEXT(a_return_emits, accept && kind == KIND_RETURN && length_q != '0, busy && !valid)
	`LEB_ASSERT_IMP(a_char_index, valid && result_kind == RK_CHAR, position < length_out)
endmodule

FILE: rtl/leb_cell.sv
`timescale 1ns / 1ps
module leb_cell import leb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [POS_W-1:0] index,
	input cell_cmd_t cmd,
	input logic [CHAR_W-1:0] left_data,
	input logic [CHAR_W-1:0] right_data,
	output logic [CHAR_W-1:0] data
);
	logic [CHAR_W-1:0] data_q;
	logic [CHAR_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (cmd.op)
			CELL_INSERT: begin
				if (index == cmd.pos) begin
					data_d = cmd.ch;
				end else if (index > cmd.pos && index <= cmd.len) begin
					data_d = left_data;
				end
			end
			// cells past the end hold spaces, so the old last cell picks one up
			CELL_DELETE: begin
				if (index >= cmd.pos && index < cmd.len) begin
					data_d = right_data;
				end
			end
			CELL_CLEAR: data_d = SPACE_CHAR;
			CELL_SHIFT: data_d = right_data;
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= SPACE_CHAR;
		end else begin
			data_q <= data_d;
		end
	end

	assign data = data_q;
endmodule

FILE: tb/line_edit_buffer_test.sv
`timescale 1ns / 1ps
module line_edit_buffer_test;
	import leb_pkg::*;

	localparam logic [3:0] KIND_OTHER = 4'd9;
	localparam logic [3:0] KIND_TOP = 4'd15;
	localparam int PHASES = 6;

	typedef struct {
		logic [3:0] kind;
		logic [7:0] code;
	} key_t;

	typedef struct packed {
		logic [1:0] rk;
		logic ap;
		logic [7:0] ch;
		logic [6:0] pos;
		logic [6:0] len;
		logic lst;
	} line_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] kind;
	logic [7:0] char_code;
	logic cfg_we;
	logic cfg_index;
	logic [6:0] cfg_data;
	logic valid;
	logic [1:0] result_kind;
	logic applied;
	logic [7:0] char_out;
	logic [6:0] position;
	logic [6:0] length_out;
	logic last;

	line_edit_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.char_code(char_code),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.valid(valid),
		.result_kind(result_kind),
		.applied(applied),
		.char_out(char_out),
		.position(position),
		.length_out(length_out),
		.last(last)
	);

	// editor image kept by the testbench
	logic [7:0] line_chars [MAX_LINE];
	int cursor_pos;
	int line_len;
	int max_len;
	bit caps_on;

	key_t key_queue[$];
	line_result_t results_due[$];
	key_t next_key;
	line_result_t seen, want;
	int idle_pct;
	int errors;
	int keys_sent;
	int returns_sent;
	int results_checked;
	int settings_used;

	function automatic line_result_t mk_result(logic [1:0] rk, logic ap, logic [7:0] ch,
			int pos, int len, logic lst);
		line_result_t r;
		r.rk = rk;
		r.ap = ap;
		r.ch = ch;
		r.pos = 7'(pos);
		r.len = 7'(len);
		r.lst = lst;
		return r;
	endfunction

	// applies one key to the image and queues the results it must produce
	function automatic void apply_key(logic [3:0] k, logic [7:0] c);
		int lim;
		int i;
		logic ap;
		logic [7:0] ch;
		ap = 1'b0;
		ch = c;
		lim = (max_len < MAX_LINE) ? max_len : MAX_LINE;
		case (k)
			KIND_CHAR: begin
				if (line_len < lim && c >= 8'd32) begin
					if (caps_on && c > 8'h60 && c < 8'h7b)
						ch = c - 8'h20;
					for (i = line_len; i > cursor_pos; i--)
						line_chars[i] = line_chars[i-1];
					line_chars[cursor_pos] = ch;
					cursor_pos++;
					line_len++;
					ap = 1'b1;
				end
			end
			KIND_BACKSPACE: begin
				if (line_len != 0 && cursor_pos != 0) begin
					for (i = cursor_pos; i < line_len; i++)
						line_chars[i-1] = line_chars[i];
					line_chars[line_len-1] = SPACE_CHAR;
					cursor_pos--;
					line_len--;
					ap = 1'b1;
				end
			end
			KIND_ERASE: begin
				if (line_len != 0 && cursor_pos < line_len) begin
					for (i = cursor_pos; i + 1 < line_len; i++)
						line_chars[i] = line_chars[i+1];
					line_chars[line_len-1] = SPACE_CHAR;
					line_len--;
					ap = 1'b1;
				end
			end
			KIND_ESCAPE: begin
				if (line_len != 0) begin
					for (i = 0; i < line_len; i++)
						line_chars[i] = SPACE_CHAR;
					line_len = 0;
					cursor_pos = 0;
					ap = 1'b1;
				end
			end
			KIND_LEFT: begin
				if (cursor_pos != 0) begin
					cursor_pos--;
					ap = 1'b1;
				end
			end
			KIND_RIGHT: begin
				if (cursor_pos < line_len) begin
					cursor_pos++;
					ap = 1'b1;
				end
			end
			KIND_HOME: begin
				if (cursor_pos != 0) begin
					cursor_pos = 0;
					ap = 1'b1;
				end
			end
			KIND_END: begin
				if (cursor_pos < line_len) begin
					cursor_pos = line_len;
					ap = 1'b1;
				end
			end
			KIND_RETURN: begin
				returns_sent++;
				if (line_len == 0) begin
					results_due.push_back(mk_result(RK_EMPTY, 1'b0, 8'h00, 0, 0, 1'b1));
				end else begin
					for (i = 0; i < line_len; i++)
						results_due.push_back(mk_result(RK_CHAR, 1'b1, line_chars[i], i,
							line_len, i + 1 == line_len));
					for (i = 0; i < line_len; i++)
						line_chars[i] = SPACE_CHAR;
					line_len = 0;
					cursor_pos = 0;
				end
				return;
			end
			default: ;
		endcase
		results_due.push_back(mk_result(RK_STATUS, ap, 8'h00, cursor_pos, line_len, 1'b1));
	endfunction

	task automatic add_key(logic [3:0] k, logic [7:0] c);
		key_t key;
		key.kind = k;
		key.code = c;
		key_queue.push_back(key);
	endtask

	// mostly inserts with edits mixed in, closed by return, escape or nothing
	task automatic add_line(int n_keys, int close_with);
		int r;
		int i;
		logic [7:0] c;
		for (i = 0; i < n_keys; i++) begin
			r = $urandom_range(99);
			c = 8'($urandom_range(255));
			if (r < 62) begin
				r = $urandom_range(99);
				if (r < 70)
					c = 8'($urandom_range(126, 32));
				else if (r < 85)
					c = 8'($urandom_range(8'h7a, 8'h61));
				add_key(KIND_CHAR, c);
			end else if (r < 70)
				add_key(KIND_LEFT, c);
			else if (r < 74)
				add_key(KIND_RIGHT, c);
			else if (r < 77)
				add_key(KIND_HOME, c);
			else if (r < 80)
				add_key(KIND_END, c);
			else if (r < 88)
				add_key(KIND_BACKSPACE, c);
			else if (r < 94)
				add_key(KIND_ERASE, c);
			else if (r < 96)
				add_key(KIND_ESCAPE, c);
			else
				add_key(4'($urandom_range(KIND_TOP, KIND_OTHER)), c);
		end
		if (close_with == 0)
			add_key(KIND_RETURN, 8'($urandom_range(255)));
		else if (close_with == 1)
			add_key(KIND_ESCAPE, 8'($urandom_range(255)));
	endtask

	task automatic write_reg(logic idx, logic [6:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_MAX_LENGTH)
			max_len = int'(data);
		else
			caps_on = data[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int ml, bit caps);
		write_reg(REG_MAX_LENGTH, 7'(ml));
		write_reg(REG_CAPS_ENABLE, {6'd0, caps});
		settings_used++;
	endtask

	// waits until every key is taken and every result has come back
	task automatic drain(int settle);
		do
			@(negedge clk);
		while (key_queue.size() != 0 || start || results_due.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				apply_key(kind, char_code);
				keys_sent++;
			end
			if (start && busy) begin
				// transaction still waiting, hold
			end else if (key_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_key = key_queue.pop_front();
				start <= 1'b1;
				kind <= next_key.kind;
				char_code <= next_key.code;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && valid) begin
			seen = '{result_kind, applied, char_out, position, length_out, last};
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result kind=%0d ap=%0d ch=%h pos=%0d len=%0d last=%0d",
					$time, seen.rk, seen.ap, seen.ch, seen.pos, seen.len, seen.lst);
				errors++;
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (seen !== want) begin
					$display("%0t: mismatch expected kind=%0d ap=%0d ch=%h pos=%0d len=%0d last=%0d",
						$time, want.rk, want.ap, want.ch, want.pos, want.len, want.lst);
					$display("%0t:          actual kind=%0d ap=%0d ch=%h pos=%0d len=%0d last=%0d",
						$time, seen.rk, seen.ap, seen.ch, seen.pos, seen.len, seen.lst);
					errors++;
				end
			end
		end
	end

	initial begin
		int ph_max [PHASES];
		bit ph_caps [PHASES];
		int ph_idle [PHASES];
		int p;
		int ml;
		ph_max = '{64, 0, 17, 1, 63, 64};
		ph_caps = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
		ph_idle = '{0, 57, 57, 35, 35, 0};
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_CHAR;
		char_code = 8'h00;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_LENGTH;
		cfg_data = 7'd0;
		idle_pct = 0;
		errors = 0;
		keys_sent = 0;
		returns_sent = 0;
		results_checked = 0;
		settings_used = 0;
		for (int i = 0; i < MAX_LINE; i++)
			line_chars[i] = SPACE_CHAR;
		cursor_pos = 0;
		line_len = 0;
		max_len = 64;
		caps_on = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// refused keys on an empty line, control bytes, edits inside a short line
		set_config(64, 1'b0);
		add_key(KIND_RETURN, 8'h00);
		add_key(KIND_BACKSPACE, 8'hff);
		add_key(KIND_ERASE, 8'h00);
		add_key(KIND_ESCAPE, 8'h00);
		add_key(KIND_LEFT, 8'h00);
		add_key(KIND_RIGHT, 8'h00);
		add_key(KIND_HOME, 8'h00);
		add_key(KIND_END, 8'h00);
		add_key(KIND_OTHER, 8'h41);
		add_key(KIND_TOP, 8'hff);
		add_key(KIND_CHAR, 8'h1f);
		add_key(KIND_CHAR, 8'h00);
		add_key(KIND_CHAR, 8'h20);
		add_key(KIND_CHAR, 8'h61);
		add_key(KIND_CHAR, 8'hff);
		add_key(KIND_LEFT, 8'h00);
		add_key(KIND_HOME, 8'h00);
		add_key(KIND_ERASE, 8'h00);
		add_key(KIND_END, 8'h00);
		add_key(KIND_RIGHT, 8'h00);
		add_key(KIND_BACKSPACE, 8'h00);
		add_key(KIND_CHAR, 8'h7e);
		add_key(KIND_RETURN, 8'h00);
		drain(8);

		// case folding at the letter boundaries, then a full line
		set_config(4, 1'b1);
		add_key(KIND_CHAR, 8'h60);
		add_key(KIND_CHAR, 8'h61);
		add_key(KIND_CHAR, 8'h7a);
		add_key(KIND_CHAR, 8'h7b);
		add_key(KIND_CHAR, 8'h62);
		add_key(KIND_RETURN, 8'h00);
		drain(8);

		for (p = 0; p < PHASES; p++) begin
			ml = (p == PHASES - 1) ? $urandom_range(64) : ph_max[p];
			set_config(ml, ph_caps[p]);
			idle_pct = ph_idle[p];
			if (p == 0) begin
				// past the 64 character limit, then emit the whole line
				for (int i = 0; i < 66; i++)
					add_key(KIND_CHAR, 8'($urandom_range(255, 32)));
				add_key(KIND_RETURN, 8'h00);
			end
			while (key_queue.size() < 15 + (p == 0 ? 67 : 0))
				add_line(($urandom_range(9) < 8) ? $urandom_range(12, 1) : $urandom_range(40, 13),
					($urandom_range(9) < 7) ? 0 : (($urandom_range(1) == 0) ? 1 : 2));
			// leave text behind so the next setting can start on a non-empty line
			add_line(5, 2);
			drain(80);
		end

		$display("Covered %0d keys (%0d returns) under %0d register settings, %0d results checked.",
			keys_sent, returns_sent, settings_used, results_checked);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl
rtl/leb_pkg.sv
rtl/leb_cell.sv
rtl/line_edit_buffer.sv
tb/line_edit_buffer_test.sv
